>>> design/mspk_pkg.sv
// Shared types, codes and the classification function of the MessagePack scalar encoder.
`default_nettype none
package mspk_pkg;

	typedef enum logic [2:0] {
		MODE_NULL = 3'd0,
		MODE_BOOL = 3'd1,
		MODE_SINT = 3'd2,
		MODE_UINT = 3'd3,
		MODE_F32  = 3'd4,
		MODE_F64  = 3'd5
	} mode_t;

	localparam logic [7:0] HDR_NIL     = 8'hC0;
	localparam logic [7:0] HDR_FALSE   = 8'hC2;
	localparam logic [7:0] HDR_TRUE    = 8'hC3;
	localparam logic [7:0] HDR_FLOAT32 = 8'hCA;
	localparam logic [7:0] HDR_FLOAT64 = 8'hCB;
	localparam logic [7:0] HDR_UINT8   = 8'hCC;
	localparam logic [7:0] HDR_UINT16  = 8'hCD;
	localparam logic [7:0] HDR_UINT32  = 8'hCE;
	localparam logic [7:0] HDR_UINT64  = 8'hCF;
	localparam logic [7:0] HDR_INT8    = 8'hD0;
	localparam logic [7:0] HDR_INT16   = 8'hD1;
	localparam logic [7:0] HDR_INT32   = 8'hD2;
	localparam logic [7:0] HDR_INT64   = 8'hD3;

	// Queue between front and back.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// One classified value: header byte, payload left-justified, payload byte count.
	typedef struct packed {
		logic [7:0]  hdr;
		logic [63:0] pay;
		logic [3:0]  nbytes;
	} job_t;

	function automatic job_t mspk_classify(input logic [2:0] mode, input logic [63:0] v);
		job_t j;
		j.hdr    = HDR_NIL;
		j.nbytes = 4'd0;
		j.pay    = 64'd0;
		unique case (mode)
			MODE_BOOL: begin
				j.hdr = (v != 64'd0) ? HDR_TRUE : HDR_FALSE;
			end
			MODE_SINT, MODE_UINT: begin
				if (mode == MODE_SINT && v[63]) begin
					if (&v[63:5]) begin
						j.hdr = v[7:0];
					end else if (&v[63:7]) begin
						j.hdr    = HDR_INT8;
						j.nbytes = 4'd1;
					end else if (&v[63:15]) begin
						j.hdr    = HDR_INT16;
						j.nbytes = 4'd2;
					end else if (&v[63:31]) begin
						j.hdr    = HDR_INT32;
						j.nbytes = 4'd4;
					end else begin
						j.hdr    = HDR_INT64;
						j.nbytes = 4'd8;
					end
				end else begin
					if (v[63:7] == 57'd0) begin
						j.hdr = v[7:0];
					end else if (v[63:8] == 56'd0) begin
						j.hdr    = HDR_UINT8;
						j.nbytes = 4'd1;
					end else if (v[63:16] == 48'd0) begin
						j.hdr    = HDR_UINT16;
						j.nbytes = 4'd2;
					end else if (v[63:32] == 32'd0) begin
						j.hdr    = HDR_UINT32;
						j.nbytes = 4'd4;
					end else begin
						j.hdr    = HDR_UINT64;
						j.nbytes = 4'd8;
					end
				end
			end
			MODE_F32: begin
				j.hdr    = HDR_FLOAT32;
				j.nbytes = 4'd4;
			end
			MODE_F64: begin
				j.hdr    = HDR_FLOAT64;
				j.nbytes = 4'd8;
			end
			default: begin
				j.hdr = HDR_NIL;
			end
		endcase
		// The back end shifts bytes out from the top, so the payload is left-justified.
		unique case (j.nbytes)
			4'd1:    j.pay = {v[7:0], 56'd0};
			4'd2:    j.pay = {v[15:0], 48'd0};
			4'd4:    j.pay = {v[31:0], 32'd0};
			4'd8:    j.pay = v;
			default: j.pay = 64'd0;
		endcase
		return j;
	endfunction

endpackage
`default_nettype wire

>>> design/mspk_front.sv
// Front end: accepts input transactions and classifies each value into a header and payload.
`default_nettype none
module mspk_front (
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [2:0]    mode,
	input  wire logic [63:0]   value,
	input  wire logic          q_full,
	output logic               q_push,
	output mspk_pkg::job_t     q_wdata
);
	import mspk_pkg::*;

	always_comb begin
		in_stall = q_full;
		q_push   = in_valid && !q_full;
		q_wdata  = mspk_classify(mode, value);
	end

endmodule
`default_nettype wire

>>> design/mspk_fifo.sv
// Short queue of classified jobs between the front and back ends.
`default_nettype none
module mspk_fifo (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	input  wire mspk_pkg::job_t wdata,
	output logic                full,
	input  wire logic           pop,
	output logic                nonempty,
	output mspk_pkg::job_t      rdata
);
	import mspk_pkg::*;

	job_t                mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wptr_q;
	logic [QPTR_W-1:0]   rptr_q;
	logic [QCNT_W-1:0]   cnt_q;

	always_comb begin
		full     = (cnt_q == QCNT_W'(QDEPTH));
		nonempty = (cnt_q != '0);
		rdata    = mem_q[rptr_q];
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (push) begin
				wptr_q <= (wptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wptr_q + 1'b1;
			end
			if (pop) begin
				rptr_q <= (rptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/mspk_back.sv
// Back end: serializes each job as a header byte followed by big-endian payload bytes.
`default_nettype none
module mspk_back (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           q_nonempty,
	input  wire mspk_pkg::job_t q_rdata,
	output logic                q_pop,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [7:0]          out_byte,
	output logic                last
);
	import mspk_pkg::*;

	logic [63:0] pay_q;
	logic [3:0]  cnt_q;
	logic        oval_q;
	logic [7:0]  obyte_q;
	logic        olast_q;
	logic        adv;
	logic        have_pay;

	always_comb begin
		adv      = !oval_q || !out_stall;
		have_pay = (cnt_q != 4'd0);
		// A new job is taken only once the current one has sent its last byte.
		q_pop    = adv && !have_pay && q_nonempty;
		out_valid = oval_q;
		out_byte  = obyte_q;
		last      = olast_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= 4'd0;
			oval_q <= 1'b0;
		end else if (adv) begin
			if (have_pay) begin
				cnt_q  <= cnt_q - 4'd1;
				oval_q <= 1'b1;
			end else if (q_nonempty) begin
				cnt_q  <= q_rdata.nbytes;
				oval_q <= 1'b1;
			end else begin
				oval_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (have_pay) begin
				obyte_q <= pay_q[63:56];
				olast_q <= (cnt_q == 4'd1);
				pay_q   <= {pay_q[55:0], 8'd0};
			end else if (q_nonempty) begin
				obyte_q <= q_rdata.hdr;
				olast_q <= (q_rdata.nbytes == 4'd0);
				pay_q   <= q_rdata.pay;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/msgpack_scalar_encoder.sv
// An accepted value is stored in the job queue, then its header byte is loaded into the output register.
// Throughput: an encoding of n bytes (1 to 9) is sent one byte per cycle while out_stall is low,
// and a queued next value's header follows its last byte with no gap; the serializer sets the rate.
// A two-entry job queue lets input transactions be taken while earlier bytes are still stalled.
// Reset (arst_n low, asynchronous) empties the queue and drops any encoding in progress.
`default_nettype none
module msgpack_scalar_encoder (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_stall,
	input  wire logic [2:0]   mode,
	input  wire logic [63:0]  value,
	output logic              out_valid,
	input  wire logic         out_stall,
	output logic [7:0]        out_byte,
	output logic              last
);
	import mspk_pkg::*;

	logic q_full;
	logic q_push;
	logic q_pop;
	logic q_nonempty;
	job_t q_wdata;
	job_t q_rdata;

	mspk_front u_front (
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.value    (value),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_wdata  (q_wdata)
	);

	mspk_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.wdata    (q_wdata),
		.full     (q_full),
		.pop      (q_pop),
		.nonempty (q_nonempty),
		.rdata    (q_rdata)
	);

	mspk_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_nonempty (q_nonempty),
		.q_rdata    (q_rdata),
		.q_pop      (q_pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last       (last)
	);

endmodule
`default_nettype wire

>>> design/mspk_checker.sv
// Port-level assertions for the MessagePack scalar encoder and the bind that attaches them.
`default_nettype none
module mspk_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [2:0]  mode,
	input wire logic [63:0] value,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  out_byte,
	input wire logic        last
);

	// A stalled input transaction keeps its valid and its payload.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(mode) && $stable(value))
		else $error("input transaction changed while stalled");

	// A stalled output transaction keeps its valid.
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("out_valid dropped while stalled");

	// A stalled output transaction keeps its payload.
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_byte) && $stable(last))
		else $error("output payload changed while stalled");

	// Bytes of one encoding follow each other with no gap.
	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_stall && !last |=> out_valid)
		else $error("gap inside an encoding");

	// The input is only held off while the output side holds a byte.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with the output idle");

endmodule

bind msgpack_scalar_encoder mspk_checker u_mspk_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.mode      (mode),
	.value     (value),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_byte  (out_byte),
	.last      (last)
);
`default_nettype wire

>>> verif/msgpack_scalar_encoder_tb.sv
// Self-checking testbench for the MessagePack scalar encoder, with a byte-level encoding predictor.
`default_nettype none
module msgpack_scalar_encoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mspk_pkg::*;

	// Modes outside the enum still have to be driven; they encode as nil.
	localparam logic [2:0] MODE_SPARE6 = 3'd6;
	localparam logic [2:0] MODE_SPARE7 = 3'd7;

	typedef struct packed {
		logic [2:0]  m;
		logic [63:0] v;
	} scalar_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} enc_byte_t;

	typedef struct packed {
		logic [3:0]  count;
		logic [71:0] bytes;
	} encoding_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  mode = 3'd0;
	logic [63:0] value = 64'd0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic        last;

	scalar_t   pending_scalars[$];
	enc_byte_t expected_bytes[$];
	logic      in_taken = 1'b0;
	logic      idle_on = 1'b1;
	int        n_queued = 0;
	int        n_accepted = 0;
	int        n_bytes_checked = 0;
	int        errors = 0;
	int        mode_hits[8];

	msgpack_scalar_encoder u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.value    (value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte (out_byte),
		.last     (last)
	);

	always #2 clk = ~clk;

	// Smallest MessagePack form of one scalar: header byte followed by a left-justified payload.
	function automatic encoding_t encode_scalar(input logic [2:0] m, input logic [63:0] v);
		encoding_t   e;
		logic [7:0]  hdr;
		logic [63:0] pay;
		int          nb;
		hdr = HDR_NIL;
		nb  = 0;
		case (m)
			MODE_BOOL: begin
				hdr = (v != 64'd0) ? HDR_TRUE : HDR_FALSE;
			end
			MODE_SINT, MODE_UINT: begin
				if (m == MODE_SINT && $signed(v) < 0) begin
					if ($signed(v) >= -64'sd32) begin
						hdr = v[7:0];
					end else if ($signed(v) >= -64'sd128) begin
						hdr = HDR_INT8;
						nb  = 1;
					end else if ($signed(v) >= -64'sd32768) begin
						hdr = HDR_INT16;
						nb  = 2;
					end else if ($signed(v) >= -64'sd2147483648) begin
						hdr = HDR_INT32;
						nb  = 4;
					end else begin
						hdr = HDR_INT64;
						nb  = 8;
					end
				end else begin
					if (v < 64'd128) begin
						hdr = v[7:0];
					end else if (v < 64'd256) begin
						hdr = HDR_UINT8;
						nb  = 1;
					end else if (v < 64'd65536) begin
						hdr = HDR_UINT16;
						nb  = 2;
					end else if (v < 64'h1_0000_0000) begin
						hdr = HDR_UINT32;
						nb  = 4;
					end else begin
						hdr = HDR_UINT64;
						nb  = 8;
					end
				end
			end
			MODE_F32: begin
				hdr = HDR_FLOAT32;
				nb  = 4;
			end
			MODE_F64: begin
				hdr = HDR_FLOAT64;
				nb  = 8;
			end
			default: begin
				hdr = HDR_NIL;
			end
		endcase
		pay = (nb == 0) ? 64'd0 : v << (64 - 8 * nb);
		e.count = 4'(nb + 1);
		e.bytes = {hdr, pay};
		return e;
	endfunction

	function automatic logic [63:0] random_value();
		logic [63:0] v;
		int          w;
		v = {$urandom, $urandom};
		case ($urandom_range(0, 9))
			0: begin
				case ($urandom_range(0, 10))
					0:       v = 64'd127;
					1:       v = 64'd128;
					2:       v = 64'd255;
					3:       v = 64'd256;
					4:       v = 64'd65535;
					5:       v = 64'd65536;
					6:       v = 64'hFFFF_FFFF;
					7:       v = 64'h1_0000_0000;
					8:       v = 64'h7FFF_FFFF_FFFF_FFFF;
					9:       v = 64'd31;
					default: v = 64'd0;
				endcase
				// The complement of a boundary is negative; some land on negative boundaries, such as -32 and -128.
				if ($urandom_range(0, 1) == 1) begin
					v = ~v;
				end
			end
			1: begin
			end
			default: begin
				w = $urandom_range(1, 63);
				v = v & ((64'd1 << w) - 64'd1);
				if ($urandom_range(0, 1) == 1) begin
					v = ~v;
				end
			end
		endcase
		if ($urandom_range(0, 7) == 0) begin
			v = 64'd0;
		end
		return v;
	endfunction

	function automatic logic [2:0] random_mode();
		int r;
		r = $urandom_range(0, 15);
		if (r < 6) return MODE_SINT;
		if (r < 10) return MODE_UINT;
		case (r)
			10:      return MODE_NULL;
			11:      return MODE_BOOL;
			12:      return MODE_F32;
			13:      return MODE_F64;
			14:      return MODE_SPARE6;
			default: return MODE_SPARE7;
		endcase
	endfunction

	task automatic queue_scalar(input logic [2:0] m, input logic [63:0] v);
		scalar_t s;
		s.m = m;
		s.v = v;
		pending_scalars.push_back(s);
		n_queued++;
	endtask

	task automatic wait_drained();
		while (n_accepted != n_queued) @(negedge clk);
		while (expected_bytes.size() != 0) @(negedge clk);
	endtask

	// Driver: a new transaction is presented only once the previous one was taken.
	always @(negedge clk) begin : driver
		scalar_t s;
		if (arst_n) begin
			if (!in_valid || in_taken) begin
				if (pending_scalars.size() != 0 &&
						!(idle_on && $urandom_range(0, 99) < 21)) begin
					s = pending_scalars.pop_front();
					in_valid <= 1'b1;
					mode     <= s.m;
					value    <= s.v;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= idle_on && ($urandom_range(0, 99) < 21);
		end
	end

	// Monitor: predicts on every input transaction and checks every output transaction.
	always @(posedge clk) begin : monitor
		encoding_t enc;
		enc_byte_t beat;
		enc_byte_t want;
		if (arst_n) begin
			in_taken <= in_valid && !in_stall;
			if (in_valid && !in_stall) begin
				enc = encode_scalar(mode, value);
				for (int i = 0; i < enc.count; i++) begin
					beat.data = enc.bytes[71 - 8 * i -: 8];
					beat.last = (i == enc.count - 1);
					expected_bytes.push_back(beat);
				end
				n_accepted++;
				mode_hits[mode]++;
			end
			if (out_valid && !out_stall) begin
				n_bytes_checked++;
				if (expected_bytes.size() == 0) begin
					errors++;
					if (errors <= 10) begin
						$display("%0t: unexpected byte %h last %b", $realtime, out_byte, last);
					end
				end else begin
					want = expected_bytes.pop_front();
					if (out_byte !== want.data || last !== want.last) begin
						errors++;
						if (errors <= 10) begin
							$display("%0t: byte exp %h got %h, last exp %b got %b",
								$realtime, want.data, out_byte, want.last, last);
						end
					end
				end
			end
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Edges of every size class, both signs, all modes and the ignored bits.
		queue_scalar(MODE_NULL, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_scalar(MODE_BOOL, 64'd0);
		queue_scalar(MODE_BOOL, 64'h8000_0000_0000_0000);
		queue_scalar(MODE_UINT, 64'd0);
		queue_scalar(MODE_UINT, 64'd127);
		queue_scalar(MODE_UINT, 64'd128);
		queue_scalar(MODE_UINT, 64'd255);
		queue_scalar(MODE_UINT, 64'd256);
		queue_scalar(MODE_UINT, 64'd65536);
		queue_scalar(MODE_UINT, 64'h1_0000_0000);
		queue_scalar(MODE_UINT, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_scalar(MODE_SINT, 64'h7FFF_FFFF_FFFF_FFFF);
		queue_scalar(MODE_SINT, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_scalar(MODE_SINT, 64'hFFFF_FFFF_FFFF_FFE0);
		queue_scalar(MODE_SINT, 64'hFFFF_FFFF_FFFF_FFDF);
		queue_scalar(MODE_SINT, 64'hFFFF_FFFF_FFFF_FF80);
		queue_scalar(MODE_SINT, 64'hFFFF_FFFF_FFFF_FF7F);
		queue_scalar(MODE_SINT, 64'hFFFF_FFFF_FFFF_8000);
		queue_scalar(MODE_SINT, 64'hFFFF_FFFF_8000_0000);
		queue_scalar(MODE_SINT, 64'hFFFF_FFFF_7FFF_FFFF);
		queue_scalar(MODE_SINT, 64'h8000_0000_0000_0000);
		queue_scalar(MODE_F32, 64'hDEAD_BEEF_3F80_0001);
		queue_scalar(MODE_F64, 64'h7FF8_0000_0000_0001);
		queue_scalar(MODE_SPARE6, 64'd5);
		queue_scalar(MODE_SPARE7, 64'hFFFF_FFFF_FFFF_FFFF);
		wait_drained();

		repeat (160) queue_scalar(random_mode(), random_value());
		wait_drained();

		// Back-to-back stretch: neither side idles.
		idle_on = 1'b0;
		repeat (100) queue_scalar(random_mode(), random_value());
		wait_drained();
		idle_on = 1'b1;

		repeat (140) queue_scalar(random_mode(), random_value());
		wait_drained();
		repeat (20) @(negedge clk);

		$display("covered %0d values: %0d int, %0d float, %0d null/bool, %0d spare mode",
			n_accepted, mode_hits[MODE_SINT] + mode_hits[MODE_UINT],
			mode_hits[MODE_F32] + mode_hits[MODE_F64],
			mode_hits[MODE_NULL] + mode_hits[MODE_BOOL],
			mode_hits[MODE_SPARE6] + mode_hits[MODE_SPARE7]);
		$display("checked %0d output bytes, %0d errors", n_bytes_checked, errors);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("timeout with %0d bytes still expected", expected_bytes.size());
		$display("status: fail");
		$finish;
	end

endmodule
`default_nettype wire

>>> sim.f
design/mspk_pkg.sv
design/mspk_front.sv
design/mspk_fifo.sv
design/mspk_back.sv
design/msgpack_scalar_encoder.sv
design/mspk_checker.sv
verif/msgpack_scalar_encoder_tb.sv
